// ===== sv/rfe_pkg.sv =====
package rfe_pkg;

    localparam int unsigned RUN_BITS   = 16;
    localparam int unsigned COEFF_BITS = 16;
    localparam int unsigned FIB_TERMS  = 32;

    // coefficient padded up to whole bytes on the input bus
    localparam int unsigned S_DATA_W = ((COEFF_BITS + 7) / 8) * 8;
    localparam int unsigned M_DATA_W = 8;
    localparam int unsigned M_USER_W = 3;

    // wide enough for every table entry up to index FIB_TERMS
    localparam int unsigned FIB_W = 23;
    localparam int unsigned IDX_W = $clog2(FIB_TERMS);

    typedef logic [FIB_W-1:0] t_fib;
    typedef logic [IDX_W-1:0] t_idx;

    localparam t_fib FIB_TAB [0:32] = '{
        23'd1,       23'd2,       23'd3,       23'd5,       23'd8,
        23'd13,      23'd21,      23'd34,      23'd55,      23'd89,
        23'd144,     23'd233,     23'd377,     23'd610,     23'd987,
        23'd1597,    23'd2584,    23'd4181,    23'd6765,    23'd10946,
        23'd17711,   23'd28657,   23'd46368,   23'd75025,   23'd121393,
        23'd196418,  23'd317811,  23'd514229,  23'd832040,  23'd1346269,
        23'd2178309, 23'd3524578, 23'd5702887
    };

    // largest value reachable with FIB_TERMS terms
    localparam t_fib FIB_LIMIT = FIB_TAB[FIB_TERMS] - t_fib'(1);

    function automatic t_fib fib_clamp(input t_fib v);
        return (v > FIB_LIMIT) ? FIB_LIMIT : v;
    endfunction

endpackage

// ===== sv/rle_fibonacci_encoder.sv =====
// Run-length / Fibonacci coefficient encoder.
// Input stream: one transfer per item. tuser is the command (0 = coefficient,
// 1 = end-of-stream flush), tdata holds the signed coefficient.
// Output stream: one transfer per packed byte, first stream bit in bit 7.
// tlast marks the final byte of an item; tuser carries byte_valid,
// stream_end and the sticky run overflow flag.
// A zero coefficient only counts the run.
// A nonzero coefficient, or a flush with a pending run, runs a single
// compare-subtract unit over the Fibonacci table, one term per cycle,
// then shifts the codeword out one bit per cycle while the output is not
// stalled. A coefficient sends a head bit, the run codeword if a run is
// pending, a sign bit and the magnitude codeword; a flush sends the head
// bit and the run codeword, then pads the partial byte. s_tready is high only
// between items.
// Completed bytes go through a one-byte hold stage so that tlast can be
// set; when the receiver stalls and both the hold stage and the output
// register are full, the bit shifter waits.
// Reset clears the run counter, the partial byte, the overflow flag and
// both output stages. A flush returns to that same state after its last
// byte (or a lone marker with byte_valid low if nothing was left).
module rle_fibonacci_encoder import rfe_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // [COEFF_BITS-1:0] coeff
    input  logic                i_s_tuser,   // cmd
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,   // [7:0] out_byte
    output logic                o_m_tlast,   // last
    output logic [M_USER_W-1:0] o_m_tuser    // [0] byte_valid, [1] stream_end,
                                             // [2] run_overflow
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_CONV,
        S_EMIT,
        S_SIGN,
        S_PAD,
        S_FINAL
    } t_state;

    t_state                r_state;
    logic [RUN_BITS-1:0]   r_run;
    logic [6:0]            r_pend;
    logic [2:0]            r_cnt;
    logic                  r_ovf;
    logic                  r_cmd;
    logic                  r_neg;
    logic                  r_has_run;
    logic                  r_seg_mag;
    logic [COEFF_BITS-1:0] r_mag;
    t_fib                  r_val;
    logic [FIB_TERMS-1:0]  r_mask;
    t_idx                  r_idx;
    t_idx                  r_top;
    logic                  r_term;
    logic                  r_hold_valid;
    logic [7:0]            r_hold_byte;
    logic                  r_out_valid;
    logic [7:0]            r_out_byte;
    logic                  r_out_bv;
    logic                  r_out_last;
    logic                  r_out_end;
    logic                  r_out_ovf;

    logic                  out_free;
    logic                  stall;
    logic                  put_en;
    logic                  put_b;
    logic                  put_go;
    logic                  pad_go;
    logic                  fin_go;
    logic                  byte_new;
    logic [7:0]            byte_val;
    logic [7:0]            pad_byte;
    logic [COEFF_BITS-1:0] coeff;
    t_fib                  fib_k;
    logic                  fib_ge;

    assign coeff      = i_s_tdata[COEFF_BITS-1:0];
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = {r_out_ovf, r_out_end, r_out_bv};

    assign out_free = !r_out_valid || i_m_tready;
    // the hold stage can only be freed into an empty output register
    assign stall    = r_hold_valid && !out_free;

    always_comb begin
        put_en = 1'b0;
        put_b  = 1'b0;
        unique case (r_state)
            S_HEAD: begin
                put_en = 1'b1;
                put_b  = !r_has_run;
            end
            S_EMIT: begin
                put_en = 1'b1;
                put_b  = r_term | r_mask[r_idx];
            end
            S_SIGN: begin
                put_en = 1'b1;
                put_b  = r_neg;
            end
            default: begin
                put_en = 1'b0;
                put_b  = 1'b0;
            end
        endcase
    end

    assign put_go   = put_en && !stall;
    assign pad_go   = (r_state == S_PAD) && !stall;
    assign fin_go   = out_free || (!r_hold_valid && !r_cmd);
    assign pad_byte = {r_pend, 1'b0} << (3'd7 - r_cnt);
    assign byte_new = (put_go && (r_cnt == 3'd7)) || (pad_go && (r_cnt != 3'd0));
    assign byte_val = (r_state == S_PAD) ? pad_byte : {r_pend, put_b};

    // shared compare-subtract unit
    assign fib_k  = FIB_TAB[r_idx];
    assign fib_ge = (r_val >= fib_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_run        <= '0;
            r_pend       <= '0;
            r_cnt        <= '0;
            r_ovf        <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            // a new byte pushes the held one out as a non-final transfer
            if (byte_new && r_hold_valid) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= r_hold_byte;
                r_out_bv    <= 1'b1;
                r_out_last  <= 1'b0;
                r_out_end   <= 1'b0;
                r_out_ovf   <= r_ovf;
            end
            if (byte_new) begin
                r_hold_valid <= 1'b1;
                r_hold_byte  <= byte_val;
            end

            if (put_go) begin
                if (r_cnt == 3'd7) begin
                    r_pend <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_pend <= {r_pend[5:0], put_b};
                    r_cnt  <= r_cnt + 3'd1;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_cmd <= i_s_tuser;
                        if (i_s_tuser) begin
                            r_has_run <= (r_run != '0);
                            r_val     <= fib_clamp(t_fib'(r_run));
                            r_run     <= '0;
                            r_state   <= (r_run != '0) ? S_HEAD : S_PAD;
                        end else if (coeff == '0) begin
                            if (r_run != '1) begin
                                r_run <= r_run + RUN_BITS'(1);
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end else begin
                            r_neg     <= coeff[COEFF_BITS-1];
                            r_mag     <= coeff[COEFF_BITS-1] ? (~coeff + COEFF_BITS'(1))
                                                             : coeff;
                            r_has_run <= (r_run != '0);
                            r_val     <= fib_clamp(t_fib'(r_run));
                            r_run     <= '0;
                            r_state   <= S_HEAD;
                        end
                    end
                end
                S_HEAD: begin
                    if (put_go) begin
                        if (r_has_run) begin
                            r_seg_mag <= 1'b0;
                            r_mask    <= '0;
                            r_idx     <= IDX_W'(FIB_TERMS - 1);
                            r_state   <= S_CONV;
                        end else begin
                            r_state <= S_SIGN;
                        end
                    end
                end
                S_SIGN: begin
                    if (put_go) begin
                        r_val     <= fib_clamp(t_fib'(r_mag));
                        r_seg_mag <= 1'b1;
                        r_mask    <= '0;
                        r_idx     <= IDX_W'(FIB_TERMS - 1);
                        r_state   <= S_CONV;
                    end
                end
                S_CONV: begin
                    // greedy from the top term down, the first hit is the top term
                    if (fib_ge) begin
                        r_val         <= r_val - fib_k;
                        r_mask[r_idx] <= 1'b1;
                        if (r_mask == '0) begin
                            r_top <= r_idx;
                        end
                    end
                    if (r_idx == '0) begin
                        r_term  <= 1'b0;
                        r_state <= S_EMIT;
                    end else begin
                        r_idx <= r_idx - IDX_W'(1);
                    end
                end
                S_EMIT: begin
                    // lowest term first, then the terminating one bit
                    if (put_go) begin
                        if (r_term) begin
                            if (r_seg_mag) begin
                                r_state <= S_FINAL;
                            end else if (r_cmd) begin
                                r_state <= S_PAD;
                            end else begin
                                r_state <= S_SIGN;
                            end
                        end else if (r_idx == r_top) begin
                            r_term <= 1'b1;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                end
                S_PAD: begin
                    if (pad_go) begin
                        r_pend  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    if (fin_go) begin
                        if (r_hold_valid) begin
                            r_out_valid  <= 1'b1;
                            r_out_byte   <= r_hold_byte;
                            r_out_bv     <= 1'b1;
                            r_out_last   <= 1'b1;
                            r_out_end    <= r_cmd;
                            r_out_ovf    <= r_ovf;
                            r_hold_valid <= 1'b0;
                        end else if (r_cmd) begin
                            // empty flush marker
                            r_out_valid <= 1'b1;
                            r_out_byte  <= '0;
                            r_out_bv    <= 1'b0;
                            r_out_last  <= 1'b1;
                            r_out_end   <= 1'b1;
                            r_out_ovf   <= r_ovf;
                        end
                        if (r_cmd) begin
                            r_run  <= '0;
                            r_pend <= '0;
                            r_cnt  <= '0;
                            r_ovf  <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_end) |-> r_out_last)
        else $error("stream end without last");

    a_marker_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_bv) |-> (r_out_end && r_out_last))
        else $error("empty marker outside a flush end");

    a_hold_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (byte_new && r_hold_valid) |-> out_free)
        else $error("held byte overwritten");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL && r_cmd && fin_go)
        |=> (r_run == '0 && r_cnt == 3'd0 && !r_ovf && !r_hold_valid))
        else $error("state not cleared after flush");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovf && !(r_state == S_FINAL && r_cmd)) |=> r_ovf)
        else $error("overflow flag dropped outside a flush");

endmodule
